// ----- sv/four_way_traffic_automaton_defines.svh -----
// Assertion macros shared by the traffic automaton RTL.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef FOUR_WAY_TRAFFIC_AUTOMATON_DEFINES_SVH
`define FOUR_WAY_TRAFFIC_AUTOMATON_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FWTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FWTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fwta_pkg.sv -----
// Types and constants of the four-way traffic automaton.
// Used by the cell and the top level; depends on nothing.
package fwta_pkg;

    typedef logic [2:0] t_cell;

    localparam t_cell CELL_EMPTY = 3'd4;

    typedef enum logic [1:0] {
        DIR_RIGHT = 2'd0,
        DIR_LEFT  = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } t_dir;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef struct packed {
        logic  tick;
        t_dir  phase;
        t_cell wr_data;
    } t_grid_cmd;

endpackage

// ----- sv/fwta_cell.sv -----
// One grid position of the traffic automaton: holds a car or nothing.
// Exchanges cars with its four torus neighbours; uses fwta_pkg.
module fwta_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fwta_pkg::t_grid_cmd i_cmd,
    input  logic                i_wr_en,
    input  fwta_pkg::t_cell     i_nb_right,
    input  fwta_pkg::t_cell     i_nb_left,
    input  fwta_pkg::t_cell     i_nb_up,
    input  fwta_pkg::t_cell     i_nb_down,
    output fwta_pkg::t_cell     o_state
);
    import fwta_pkg::*;

    t_cell r_state;
    t_cell n_state;
    t_cell w_target;
    t_cell w_source;
    t_cell w_dir;

    assign w_dir = {1'b0, i_cmd.phase};

    always_comb begin
        unique case (i_cmd.phase)
            DIR_RIGHT: begin
                w_target = i_nb_right;
                w_source = i_nb_left;
            end
            DIR_LEFT: begin
                w_target = i_nb_left;
                w_source = i_nb_right;
            end
            DIR_UP: begin
                w_target = i_nb_up;
                w_source = i_nb_down;
            end
            DIR_DOWN: begin
                w_target = i_nb_down;
                w_source = i_nb_up;
            end
            default: begin
                w_target = i_nb_right;
                w_source = i_nb_left;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        if (i_wr_en) begin
            n_state = i_cmd.wr_data;
        end else if (i_cmd.tick) begin
            if (r_state == w_dir && w_target == CELL_EMPTY) begin
                n_state = CELL_EMPTY;
            end else if (r_state == CELL_EMPTY && w_source == w_dir) begin
                n_state = w_dir;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CELL_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// ----- sv/four_way_traffic_automaton.sv -----
// Top level of the four-way traffic automaton: cell array, control and read path.
// Uses fwta_pkg, fwta_cell and four_way_traffic_automaton_defines.svh.
//
// Usage: each input item on the s_axis channel carries an operation in tuser
// (write a cell, tick, or read a cell; the unused code reads) and a cell
// address and value in tdata. Every item returns one output item on m_axis
// holding the addressed cell after the operation and the phase, i.e. the car
// direction that moves on the next tick. Addresses outside the grid are not
// written and read back as empty.
// A tick moves every car of the current phase whose target cell is empty, all at
// once in the accepting cycle. The read passes a per-column multiplexer stage
// and then a column select stage before the result is presented.
// Only one item is in flight: no new item is taken until the last result has
// been taken. While a result waits, s_axis_tready stays low and the result
// holds until m_axis_tready is seen high.
// Reset empties every cell and sets the phase to right.
`include "four_way_traffic_automaton_defines.svh"

module four_way_traffic_automaton #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // column[5:0], row[11:6], cell_in[14:12], zero
    input  logic [1:0]  s_axis_tuser,  // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata   // cell_out[2:0], phase[4:3], zero
);
    import fwta_pkg::*;

    localparam int CW = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
    localparam int RW = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COL  = 4'b0010,
        S_SEL  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state    r_state;
    t_state    n_state;
    t_dir      r_phase;
    logic [CW-1:0] r_col_idx;
    logic [RW-1:0] r_row_idx;
    logic      r_inside;
    t_cell     r_colv [GRID_WIDTH];
    t_cell     r_cell_out;

    t_cell     w_cell [GRID_WIDTH][GRID_HEIGHT];
    logic [5:0] w_col_in;
    logic [5:0] w_row_in;
    logic [2:0] w_val_in;
    logic      w_accept;
    logic      w_inside;
    logic      w_do_write;
    logic [CW-1:0] w_col_idx;
    logic [RW-1:0] w_row_idx;
    t_grid_cmd w_cmd;

    assign w_col_in  = s_axis_tdata[5:0];
    assign w_row_in  = s_axis_tdata[11:6];
    assign w_val_in  = s_axis_tdata[14:12];
    assign w_accept  = s_axis_tvalid && s_axis_tready;
    assign w_inside  = (32'(w_col_in) < GRID_WIDTH) && (32'(w_row_in) < GRID_HEIGHT);
    assign w_col_idx = CW'(w_col_in);
    assign w_row_idx = RW'(w_row_in);
    assign w_do_write = w_accept && (s_axis_tuser == OP_WRITE) && w_inside;

    assign w_cmd.tick    = w_accept && (s_axis_tuser == OP_TICK);
    assign w_cmd.phase   = r_phase;
    assign w_cmd.wr_data = (w_val_in > CELL_EMPTY) ? CELL_EMPTY : w_val_in;

    for (genvar c = 0; c < GRID_WIDTH; c++) begin : g_col
        localparam int CR = (c + 1) % GRID_WIDTH;
        localparam int CL = (c + GRID_WIDTH - 1) % GRID_WIDTH;
        for (genvar r = 0; r < GRID_HEIGHT; r++) begin : g_row
            localparam int RU = (r + 1) % GRID_HEIGHT;
            localparam int RD = (r + GRID_HEIGHT - 1) % GRID_HEIGHT;
            logic w_wr_en;
            assign w_wr_en = w_do_write && (w_col_idx == CW'(c)) && (w_row_idx == RW'(r));
            fwta_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_cmd      (w_cmd),
                .i_wr_en    (w_wr_en),
                .i_nb_right (w_cell[CR][r]),
                .i_nb_left  (w_cell[CL][r]),
                .i_nb_up    (w_cell[c][RU]),
                .i_nb_down  (w_cell[c][RD]),
                .o_state    (w_cell[c][r])
            );
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_COL;
            S_COL:  n_state = S_SEL;
            S_SEL:  n_state = S_OUT;
            S_OUT:  if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= DIR_RIGHT;
        end else begin
            r_state <= n_state;
            if (w_cmd.tick) begin
                r_phase <= t_dir'(r_phase + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_col_idx <= w_col_idx;
            r_row_idx <= w_row_idx;
            r_inside  <= w_inside;
        end
        if (r_state == S_COL) begin
            for (int c = 0; c < GRID_WIDTH; c++) begin
                r_colv[c] <= w_cell[c][r_row_idx];
            end
        end
        if (r_state == S_SEL) begin
            r_cell_out <= r_inside ? r_colv[r_col_idx] : CELL_EMPTY;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {3'b000, r_phase, r_cell_out};

    `FWTA_ASSERT_NOW(a_one_side, i_clk, i_rst_n, 1'b1,
        !(s_axis_tready && m_axis_tvalid), "input taken while a result is pending")
    `FWTA_ASSERT_NEXT(a_phase_step, i_clk, i_rst_n, w_cmd.tick,
        r_phase == t_dir'($past(r_phase) + 2'd1), "phase did not advance on a tick")
    `FWTA_ASSERT_NEXT(a_result_due, i_clk, i_rst_n, r_state == S_SEL,
        m_axis_tvalid && $stable(r_phase), "result not presented after the select stage")

endmodule
